>>> rtl/core/hsp_pkg.sv
// Shared types and constants for the cubic Hermite spline point evaluator.
// No dependencies; imported by hsp_blend and hermite_spline_point_2d.
package hsp_pkg;

    // Four basis terms per axis: p0, t0, p1, t1
    localparam int NUM_TERMS  = 4;
    // Eight input coordinates, x and y interleaved: p0, t0, p1, t1
    localparam int NUM_COORDS = 2 * NUM_TERMS;

    // Stage advance strobes handed to the per-axis blend datapath
    typedef struct packed {
        logic mul_en;   // product stage loads
        logic sum_en;   // sum / saturate stage loads
    } hsp_adv_t;

endpackage

>>> rtl/core/hermite_spline_point_2d.sv
// Cubic Hermite spline point evaluator, 2D, stream in / stream out.
// One item per cycle sustained while the output accepts (m_axis_tready high).
// Stages: s^2, s^3, basis weights, rounded products, sum/saturate.
// Stages advance independently, so bubbles close up under output backpressure.
// Reset (rst_n low, async) clears all stage valid bits; data registers are not reset.
// Depends on hsp_pkg and hsp_blend.
module hermite_spline_point_2d #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // lsb up: p0_x, p0_y, t0_x, t0_y, p1_x, p1_y, t1_x, t1_y, param_s, zero pad
    input  logic [((8*COORD_WIDTH+FRAC_BITS+1+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // lsb up: out_x, out_y, saturated, zero pad
    output logic [((2*COORD_WIDTH+1+7)/8)*8-1:0] m_axis_tdata
);
    import hsp_pkg::*;

    localparam int W      = COORD_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int S_W    = F + 1;
    localparam int SQ_W   = 2 * F + 2;
    localparam int WW     = F + 3;
    localparam int MAG_W  = F + 2;
    localparam int OUT_W  = ((2*COORD_WIDTH+1+7)/8)*8;
    localparam int OUT_PAD = OUT_W - 2 * W - 1;

    // Stage valid bits and advance strobes
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;
    hsp_adv_t adv;

    // Stage payloads
    logic [W-1:0]   c_mag_in  [NUM_COORDS];
    logic           c_neg_in  [NUM_COORDS];
    logic [W-1:0]   s1_mag_reg [NUM_COORDS];
    logic           s1_neg_reg [NUM_COORDS];
    logic [W-1:0]   s2_mag_reg [NUM_COORDS];
    logic           s2_neg_reg [NUM_COORDS];
    logic [W-1:0]   s3_mag_reg [NUM_COORDS];
    logic           s3_neg_reg [NUM_COORDS];

    logic [S_W-1:0]  s_raw, s_clamp, s2_next, s3_next;
    logic [SQ_W-1:0] sq, cube;
    logic [S_W-1:0]  s1_s_reg, s1_sq_reg;
    logic [S_W-1:0]  s2_s_reg, s2_sq_reg, s2_cube_reg;

    logic signed [WW-1:0] se, s2e, s3e, one_q;
    logic signed [WW-1:0] wt [NUM_TERMS];
    logic [MAG_W-1:0] wt_mag_next [NUM_TERMS];
    logic [MAG_W-1:0] wt_mag_reg  [NUM_TERMS];
    logic             wt_neg_reg  [NUM_TERMS];

    logic [W-1:0] x_mag [NUM_TERMS];
    logic         x_neg [NUM_TERMS];
    logic [W-1:0] y_mag [NUM_TERMS];
    logic         y_neg [NUM_TERMS];
    logic [W-1:0] out_x, out_y;
    logic         sat_x, sat_y;

    // Handshake: a stage loads when it is empty or its content moves on
    assign en5 = !v5_reg || m_axis_tready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_axis_tready = en1;
    assign adv.mul_en = en4;
    assign adv.sum_en = en5;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= s_axis_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    // Stage 1: unpack, coordinate magnitudes, clamp s, s^2 rounded
    always_comb
    begin
        for (int i = 0; i < NUM_COORDS; i++)
        begin
            c_neg_in[i] = s_axis_tdata[i*W + W - 1];
            c_mag_in[i] = c_neg_in[i] ? (W'(0) - s_axis_tdata[i*W +: W])
                                      : s_axis_tdata[i*W +: W];
        end
        s_raw   = s_axis_tdata[NUM_COORDS*W +: S_W];
        s_clamp = (s_raw > (S_W'(1) << F)) ? (S_W'(1) << F) : s_raw;
        sq      = SQ_W'(s_clamp) * SQ_W'(s_clamp) + (SQ_W'(1) << (F - 1));
        s2_next = sq[2*F:F];
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_s_reg  <= s_clamp;
            s1_sq_reg <= s2_next;
            for (int i = 0; i < NUM_COORDS; i++)
            begin
                s1_mag_reg[i] <= c_mag_in[i];
                s1_neg_reg[i] <= c_neg_in[i];
            end
        end
    end

    // Stage 2: s^3 rounded
    always_comb
    begin
        cube    = SQ_W'(s1_sq_reg) * SQ_W'(s1_s_reg) + (SQ_W'(1) << (F - 1));
        s3_next = cube[2*F:F];
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_s_reg    <= s1_s_reg;
            s2_sq_reg   <= s1_sq_reg;
            s2_cube_reg <= s3_next;
            for (int i = 0; i < NUM_COORDS; i++)
            begin
                s2_mag_reg[i] <= s1_mag_reg[i];
                s2_neg_reg[i] <= s1_neg_reg[i];
            end
        end
    end

    // Stage 3: basis weights h00, h10, h01, h11 as sign and magnitude
    always_comb
    begin
        se    = $signed(WW'(s2_s_reg));
        s2e   = $signed(WW'(s2_sq_reg));
        s3e   = $signed(WW'(s2_cube_reg));
        one_q = $signed(WW'(1) << F);
        wt[0] = (s3e <<< 1) - (s2e <<< 1) - s2e + one_q;
        wt[1] = s3e - (s2e <<< 1) + se;
        wt[2] = (s2e <<< 1) + s2e - (s3e <<< 1);
        wt[3] = s3e - s2e;
        for (int i = 0; i < NUM_TERMS; i++)
        begin
            wt_mag_next[i] = wt[i][WW-1] ? MAG_W'(-wt[i]) : MAG_W'(wt[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            for (int i = 0; i < NUM_TERMS; i++)
            begin
                wt_mag_reg[i] <= wt_mag_next[i];
                wt_neg_reg[i] <= wt[i][WW-1];
            end
            for (int i = 0; i < NUM_COORDS; i++)
            begin
                s3_mag_reg[i] <= s2_mag_reg[i];
                s3_neg_reg[i] <= s2_neg_reg[i];
            end
        end
    end

    // Split interleaved coordinates into x and y term lists
    always_comb
    begin
        for (int i = 0; i < NUM_TERMS; i++)
        begin
            x_mag[i] = s3_mag_reg[2*i];
            x_neg[i] = s3_neg_reg[2*i];
            y_mag[i] = s3_mag_reg[2*i+1];
            y_neg[i] = s3_neg_reg[2*i+1];
        end
    end

    // Stages 4 and 5: products and saturated sums, one datapath per axis
    hsp_blend #(
        .FRAC_BITS   (FRAC_BITS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_blend_x (
        .clk       (clk),
        .adv       (adv),
        .coord_mag (x_mag),
        .coord_neg (x_neg),
        .wt_mag    (wt_mag_reg),
        .wt_neg    (wt_neg_reg),
        .result    (out_x),
        .clamped   (sat_x)
    );

    hsp_blend #(
        .FRAC_BITS   (FRAC_BITS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_blend_y (
        .clk       (clk),
        .adv       (adv),
        .coord_mag (y_mag),
        .coord_neg (y_neg),
        .wt_mag    (wt_mag_reg),
        .wt_neg    (wt_neg_reg),
        .result    (out_y),
        .clamped   (sat_y)
    );

    // Output transaction
    assign m_axis_tvalid = v5_reg;
    assign m_axis_tdata  = {{OUT_PAD{1'b0}}, sat_x | sat_y, out_y, out_x};

endmodule

>>> rtl/core/hsp_blend.sv
// Per-axis back end: four rounded coordinate-by-weight products, then the
// signed sum with saturation. Two register stages. Depends on hsp_pkg.
module hsp_blend #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                   clk,
    input  hsp_pkg::hsp_adv_t      adv,
    input  logic [COORD_WIDTH-1:0] coord_mag [hsp_pkg::NUM_TERMS],
    input  logic                   coord_neg [hsp_pkg::NUM_TERMS],
    input  logic [FRAC_BITS+1:0]   wt_mag    [hsp_pkg::NUM_TERMS],
    input  logic                   wt_neg    [hsp_pkg::NUM_TERMS],
    output logic [COORD_WIDTH-1:0] result,
    output logic                   clamped
);
    import hsp_pkg::*;

    localparam int MAG_W  = FRAC_BITS + 2;
    localparam int PROD_W = COORD_WIDTH + MAG_W;
    localparam int RMAG_W = COORD_WIDTH + 2;
    localparam int SUM_W  = COORD_WIDTH + 5;
    localparam int TOP_W  = SUM_W - COORD_WIDTH + 1;

    logic [RMAG_W-1:0]      rmag_next [NUM_TERMS];
    logic [RMAG_W-1:0]      rmag_reg  [NUM_TERMS];
    logic                   rneg_reg  [NUM_TERMS];
    logic [PROD_W-1:0]      prod      [NUM_TERMS];
    logic [SUM_W-1:0]       term      [NUM_TERMS];
    logic [SUM_W-1:0]       sum;
    logic [TOP_W-1:0]       sum_top;
    logic [COORD_WIDTH-1:0] result_next;
    logic                   clamped_next;
    logic [COORD_WIDTH-1:0] result_reg;
    logic                   clamped_reg;

    // Magnitude products, rounded half up on the magnitude (ties away from zero)
    always_comb
    begin
        for (int i = 0; i < NUM_TERMS; i++)
        begin
            prod[i] = PROD_W'(coord_mag[i]) * PROD_W'(wt_mag[i])
                    + (PROD_W'(1) << (FRAC_BITS - 1));
            rmag_next[i] = prod[i][PROD_W-1:FRAC_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.mul_en)
        begin
            for (int i = 0; i < NUM_TERMS; i++)
            begin
                rmag_reg[i] <= rmag_next[i];
                rneg_reg[i] <= coord_neg[i] ^ wt_neg[i];
            end
        end
    end

    // Apply signs, sum exactly, clamp to the coordinate range
    always_comb
    begin
        for (int i = 0; i < NUM_TERMS; i++)
        begin
            term[i] = rneg_reg[i] ? (SUM_W'(0) - SUM_W'(rmag_reg[i]))
                                  : SUM_W'(rmag_reg[i]);
        end
        sum     = term[0] + term[1] + term[2] + term[3];
        sum_top = sum[SUM_W-1:COORD_WIDTH-1];
        if (sum_top == '0 || sum_top == '1)
        begin
            result_next  = sum[COORD_WIDTH-1:0];
            clamped_next = 1'b0;
        end
        else if (sum[SUM_W-1])
        begin
            result_next  = {1'b1, {(COORD_WIDTH-1){1'b0}}};
            clamped_next = 1'b1;
        end
        else
        begin
            result_next  = {1'b0, {(COORD_WIDTH-1){1'b1}}};
            clamped_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.sum_en)
        begin
            result_reg  <= result_next;
            clamped_reg <= clamped_next;
        end
    end

    assign result  = result_reg;
    assign clamped = clamped_reg;

endmodule
